### rtl/core/msp_pkg.sv
`timescale 1ns / 1ps

package msp_pkg;

    // Fixed widths of the stream fields, the configuration registers and their index.
    localparam int SPEED_W  = 16;
    localparam int GAIN_W   = 10;
    localparam int SMAX_W   = 15;
    localparam int SENS_W   = 8;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 3;

    // Launch hysteresis thresholds on the speed error.
    localparam int LAUNCH_ON  = 15;
    localparam int LAUNCH_OFF = 5;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FF    = 3'd0,
        REG_KP    = 3'd1,
        REG_KI    = 3'd2,
        REG_KD    = 3'd3,
        REG_SMAX  = 3'd4,
        REG_DRUN  = 3'd5,
        REG_DREST = 3'd6,
        REG_SENS  = 3'd7
    } msp_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EVAL,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_INTEG,
        ST_SCALE,
        ST_DIV,
        ST_OUT
    } msp_state_t;

    typedef struct packed {
        logic load_in;
        logic eval;
        logic mul_base;
        logic mul_prop;
        logic mul_deriv;
        logic add_integ;
        logic div_start;
        logic finish;
        logic out_load;
    } msp_cmd_t;

    typedef struct packed {
        logic launch;
        logic div_busy;
        logic out_free;
    } msp_status_t;

endpackage

### rtl/core/msp_div.sv
`timescale 1ns / 1ps

module msp_div #(
    parameter int DVW = 27,
    parameter int DSW = 15
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic signed [DVW-1:0] dividend,
    input  logic [DSW-1:0]        divisor,
    output logic                  busy,
    output logic signed [DVW-1:0] quotient
);

    // Two restoring steps per cycle on the magnitude, sign applied at the end.
    localparam int STEPS = (DVW + 1) / 2;
    localparam int QW    = 2 * STEPS;
    localparam int CW    = $clog2(STEPS);

    logic [QW-1:0]  quo_reg;
    logic [QW-1:0]  quo_next;
    logic [DSW-1:0] rem_reg;
    logic [DSW-1:0] rem_next;
    logic [DSW-1:0] dsr_reg;
    logic [CW-1:0]  cnt_reg;
    logic           neg_reg;
    logic           busy_reg;
    logic [DVW-1:0] mag_in;
    logic [DVW-1:0] quo_trim;

    assign mag_in = dividend[DVW-1] ? (~dividend + 1'b1) : dividend;

    always_comb
    begin
        logic [DSW:0]   sh;
        logic [DSW-1:0] r;
        logic [QW-1:0]  q;
        r = rem_reg;
        q = quo_reg;
        for (int k = 0; k < 2; k++)
        begin
            sh = {r, q[QW-1]};
            q  = {q[QW-2:0], 1'b0};
            if (sh >= {1'b0, dsr_reg})
            begin
                sh   = sh - {1'b0, dsr_reg};
                q[0] = 1'b1;
            end
            r = sh[DSW-1:0];
        end
        rem_next = r;
        quo_next = q;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CW'(STEPS - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= QW'(mag_in);
            rem_reg <= '0;
            dsr_reg <= divisor;
            neg_reg <= dividend[DVW-1];
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign quo_trim = quo_reg[DVW-1:0];
    assign quotient = neg_reg ? -$signed(quo_trim) : $signed(quo_trim);
    assign busy     = busy_reg;

    a_busy_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !start && cnt_reg == CW'(STEPS - 1)) |=> !busy_reg)
        else $error("divider did not finish after its last step");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> (busy_reg && cnt_reg == '0))
        else $error("divider did not begin after start");

    a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (!busy_reg && !start) |=> !busy_reg)
        else $error("divider became busy without start");

endmodule

### rtl/core/msp_datapath.sv
`timescale 1ns / 1ps

module msp_datapath #(
    parameter int VALUE_WIDTH = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  msp_pkg::msp_cmd_t      cmd,
    output msp_pkg::msp_status_t   status,
    input  logic [31:0]            in_data,
    input  logic                   cfg_we,
    input  logic [2:0]             cfg_index,
    input  logic [15:0]            cfg_wdata,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [15:0]            out_data
);

    import msp_pkg::*;

    localparam int W   = VALUE_WIDTH;
    localparam int EW  = (W > SPEED_W) ? W : SPEED_W;
    localparam int AW  = W + GAIN_W;
    localparam int DVW = W + GAIN_W + 1;

    // The integral product is divided by 100 through a multiplication with a
    // rounded-up reciprocal; the shift keeps the error below one quotient step.
    localparam int RW = AW + 1;
    localparam int LW = (AW + 1) / 2;
    localparam int HW = AW - LW;
    localparam int SH = AW + 7;
    localparam logic [63:0]   RECIP_WIDE = ((64'd1 << SH) + 64'd99) / 64'd100;
    localparam logic [RW-1:0] RECIP      = RW'(RECIP_WIDE);

    // Configuration registers.
    logic [GAIN_W-1:0]         ff_reg;
    logic [GAIN_W-1:0]         kp_reg;
    logic [GAIN_W-1:0]         ki_reg;
    logic [GAIN_W-1:0]         kd_reg;
    logic [SMAX_W-1:0]         smax_reg;
    logic signed [SPEED_W-1:0] drun_reg;
    logic signed [SPEED_W-1:0] drest_reg;
    logic [SENS_W-1:0]         sens_reg;

    // Controller state kept across words.
    logic                      launch_reg;
    logic                      launch_next;
    logic signed [W-1:0]       sum_reg;
    logic signed [W-1:0]       prev_reg;

    // Per-word working registers.
    logic signed [SPEED_W-1:0] t_reg;
    logic signed [SPEED_W-1:0] m_reg;
    logic signed [W-1:0]       err_reg;
    logic signed [W-1:0]       diff_reg;
    logic signed [W-1:0]       acc_reg;
    logic [AW-1:0]             imag_reg;
    logic                      ineg_reg;
    logic [LW+RW-1:0]          ilo_reg;
    logic [HW+RW-1:0]          ihi_reg;
    logic signed [W-1:0]       iq_reg;
    logic [SPEED_W-1:0]        res_reg;
    logic [SPEED_W-1:0]        out_data_reg;
    logic                      out_valid_reg;

    logic signed [EW-1:0]      t_ext;
    logic signed [EW-1:0]      m_ext;
    logic signed [EW-1:0]      diff_ext;
    logic signed [W-1:0]       err_w;
    logic                      launch_take;
    logic [AW-1:0]             base_prod;
    logic [AW-1:0]             prop_prod;
    logic [AW-1:0]             deriv_prod;
    logic [W-1:0]              sum_abs;
    logic [AW-1:0]             imag_next;
    logic [LW+RW-1:0]          ilo_next;
    logic [HW+RW-1:0]          ihi_next;
    logic [AW+RW-1:0]          iprod;
    logic [W-1:0]              iq_mag;
    logic signed [W-1:0]       iq_next;
    logic signed [DVW-1:0]     acc_x;
    logic signed [DVW-1:0]     scaled;
    logic signed [DVW-1:0]     div_quo;
    logic                      div_busy;
    logic [W-1:0]              q_w;
    logic [W+SENS_W-1:0]       sens_prod;
    logic signed [SPEED_W-1:0] off_sel;
    logic signed [EW-1:0]      off_ext;
    logic signed [W-1:0]       run_w;
    logic signed [EW-1:0]      run_ext;

    assign t_ext    = EW'(t_reg);
    assign m_ext    = EW'(m_reg);
    assign diff_ext = t_ext - m_ext;
    assign err_w    = diff_ext[W-1:0];

    // The launch flag latches on a large error and releases below the lower threshold.
    assign launch_take = launch_reg || (err_w > W'(LAUNCH_ON));
    assign launch_next = launch_take && !(err_w < W'(LAUNCH_OFF));

    assign base_prod  = AW'(t_ext[W-1:0]) * AW'(ff_reg);
    assign prop_prod  = AW'(err_reg) * AW'(kp_reg);
    assign deriv_prod = AW'(diff_reg) * AW'(kd_reg);

    // The integral quotient is formed on magnitudes and truncates toward zero.
    assign sum_abs   = sum_reg[W-1] ? (~sum_reg + 1'b1) : sum_reg;
    assign imag_next = AW'(sum_abs) * AW'(ki_reg);
    assign ilo_next  = (LW+RW)'(imag_reg[LW-1:0]) * (LW+RW)'(RECIP);
    assign ihi_next  = (HW+RW)'(imag_reg[AW-1:LW]) * (HW+RW)'(RECIP);
    assign iprod     = ((AW+RW)'(ihi_reg) << LW) + (AW+RW)'(ilo_reg);
    assign iq_mag    = iprod[SH+W-1:SH];
    assign iq_next   = ineg_reg ? (~iq_mag + 1'b1) : iq_mag;

    assign acc_x  = DVW'(acc_reg);
    assign scaled = (acc_x <<< 6) + (acc_x <<< 5) + (acc_x <<< 2);

    // A zero full-scale setting forces the scaled value to zero.
    assign q_w       = (smax_reg == '0) ? '0 : div_quo[W-1:0];
    assign sens_prod = (W+SENS_W)'(q_w) * (W+SENS_W)'(sens_reg);
    assign off_sel   = (m_reg != '0) ? drun_reg : drest_reg;
    assign off_ext   = EW'(off_sel);
    assign run_w     = off_ext[W-1:0] + sens_prod[W-1:0];
    assign run_ext   = EW'(run_w);

    msp_div #(
        .DVW (DVW),
        .DSW (SMAX_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (scaled),
        .divisor  (smax_reg),
        .busy     (div_busy),
        .quotient (div_quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ff_reg    <= '0;
            kp_reg    <= '0;
            ki_reg    <= '0;
            kd_reg    <= '0;
            smax_reg  <= SMAX_W'(100);
            drun_reg  <= '0;
            drest_reg <= '0;
            sens_reg  <= SENS_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (msp_reg_t'(cfg_index))
                REG_FF:    ff_reg    <= cfg_wdata[GAIN_W-1:0];
                REG_KP:    kp_reg    <= cfg_wdata[GAIN_W-1:0];
                REG_KI:    ki_reg    <= cfg_wdata[GAIN_W-1:0];
                REG_KD:    kd_reg    <= cfg_wdata[GAIN_W-1:0];
                REG_SMAX:  smax_reg  <= cfg_wdata[SMAX_W-1:0];
                REG_DRUN:  drun_reg  <= cfg_wdata;
                REG_DREST: drest_reg <= cfg_wdata;
                REG_SENS:  sens_reg  <= cfg_wdata[SENS_W-1:0];
                default:   ff_reg    <= ff_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            launch_reg    <= 1'b0;
            sum_reg       <= '0;
            prev_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.eval)
            begin
                launch_reg <= launch_next;
            end
            if (cmd.add_integ)
            begin
                sum_reg  <= sum_reg + err_reg;
                prev_reg <= err_reg;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            t_reg <= in_data[15:0];
            m_reg <= in_data[31:16];
        end
        if (cmd.eval)
        begin
            err_reg <= err_w;
            if (launch_take)
            begin
                res_reg <= {1'b0, smax_reg};
            end
        end
        if (cmd.mul_base)
        begin
            acc_reg  <= base_prod[W-1:0];
            diff_reg <= err_reg - prev_reg;
            imag_reg <= imag_next;
            ineg_reg <= sum_reg[W-1];
        end
        if (cmd.mul_prop)
        begin
            acc_reg <= acc_reg + prop_prod[W-1:0];
            ilo_reg <= ilo_next;
            ihi_reg <= ihi_next;
        end
        if (cmd.mul_deriv)
        begin
            acc_reg <= acc_reg + deriv_prod[W-1:0];
            iq_reg  <= iq_next;
        end
        if (cmd.add_integ)
        begin
            acc_reg <= acc_reg + iq_reg;
        end
        if (cmd.finish)
        begin
            res_reg <= run_ext[SPEED_W-1:0];
        end
        if (cmd.out_load)
        begin
            out_data_reg <= res_reg;
        end
    end

    assign status.launch   = launch_take;
    assign status.div_busy = div_busy;
    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign out_data        = out_data_reg;

endmodule

### rtl/core/msp_ctrl.sv
`timescale 1ns / 1ps

module msp_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  msp_pkg::msp_status_t status,
    output msp_pkg::msp_cmd_t    cmd
);

    import msp_pkg::*;

    msp_state_t state_reg;
    msp_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:  state_next = status.launch ? ST_OUT : ST_MUL1;
            ST_MUL1:  state_next = ST_MUL2;
            ST_MUL2:  state_next = ST_MUL3;
            ST_MUL3:  state_next = ST_INTEG;
            ST_INTEG: state_next = ST_SCALE;
            ST_SCALE: state_next = ST_DIV;
            ST_DIV:
            begin
                if (!status.div_busy)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
            end
            ST_EVAL:  cmd.eval = 1'b1;
            ST_MUL1:  cmd.mul_base = 1'b1;
            ST_MUL2:  cmd.mul_prop = 1'b1;
            ST_MUL3:  cmd.mul_deriv = 1'b1;
            ST_INTEG: cmd.add_integ = 1'b1;
            ST_SCALE: cmd.div_start = 1'b1;
            ST_DIV:   cmd.finish = !status.div_busy;
            ST_OUT:   cmd.out_load = status.out_free;
            default:  cmd = '0;
        endcase
    end

    a_start_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !status.div_busy)
        else $error("divide started while the divider was busy");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> status.out_free)
        else $error("result loaded over a word not yet taken");

    a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_EVAL))
        else $error("accepted word was not taken into evaluation");

endmodule

### rtl/core/motor_speed_pid_with_launch.sv
`timescale 1ns / 1ps

// PID speed controller with feedforward and a launch mode.
// Input stream: one word per control tick, carrying target and measured speed.
// Output stream: one drive word per input word, in order.
// Configuration: write cfg_wdata to register cfg_index while cfg_we is high;
// the user must change gains, full-scale speed, dead-band offsets and output
// sensitivity only while no word is in flight; the block does not enforce it.
// One word is processed at a time. A word in launch mode goes from evaluation
// straight to the output state and reaches the output register before the
// next word is accepted. A regular word passes the multiply, integral and
// scale states and then waits on the serial divider, two quotient bits per
// cycle, which scales the output by the full-scale speed; it reaches the
// output register before the next word can be accepted. The integral division
// by 100 is a reciprocal multiplication spread over the states MUL1 to MUL3.
// The finished drive word sits in an output register, so the next input word
// is accepted while it waits; if the receiver stalls, the following word
// holds in the last state until the output register frees.
// Reset clears the launch flag, the error sum and the previous error, and
// loads the configuration registers with their defaults.
module motor_speed_pid_with_launch #(
    parameter int VALUE_WIDTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [15:0] target_speed, [31:16] measured_speed
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] drive
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);

    import msp_pkg::*;

    msp_cmd_t    cmd;
    msp_status_t status;

    msp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    msp_datapath #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_data   (s_axis_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule

### test/tb_motor_speed_pid_with_launch.sv
`timescale 1ns / 1ps

module tb_motor_speed_pid_with_launch;

    import msp_pkg::*;

    localparam int IDLE_LIMIT   = 5000;
    localparam int RX_HOLD      = 400;
    localparam int SETTLE_WAIT  = 48;
    localparam int RANDOM_TICKS = 100;
    localparam int RANDOM_SETS  = 7;

    // Holds the controller state and settings, and the drive words still owed by the block.
    class drive_tracker;
        typedef struct {
            logic signed [15:0] tgt;
            logic signed [15:0] meas;
            logic signed [15:0] drive;
        } tick_t;

        logic [9:0]         ff_gain;
        logic [9:0]         p_gain;
        logic [9:0]         i_gain;
        logic [9:0]         d_gain;
        logic [14:0]        smax;
        logic signed [15:0] run_offset;
        logic signed [15:0] rest_offset;
        logic [7:0]         sens;
        bit                 launching;
        logic signed [15:0] err_sum;
        logic signed [15:0] last_err;
        tick_t              drive_due[$];
        int                 mismatches;

        function new();
            ff_gain     = '0;
            p_gain      = '0;
            i_gain      = '0;
            d_gain      = '0;
            smax        = 15'd100;
            run_offset  = '0;
            rest_offset = '0;
            sens        = 8'd1;
            launching   = 1'b0;
            err_sum     = '0;
            last_err    = '0;
            mismatches  = 0;
        endfunction

        function longint wrap16(longint x);
            logic signed [15:0] t;
            t = x[15:0];
            return t;
        endfunction

        function void set_reg(msp_reg_t idx, logic [15:0] v);
            case (idx)
                REG_FF:    ff_gain = v[9:0];
                REG_KP:    p_gain = v[9:0];
                REG_KI:    i_gain = v[9:0];
                REG_KD:    d_gain = v[9:0];
                REG_SMAX:  smax = v[14:0];
                REG_DRUN:  run_offset = v;
                REG_DREST: rest_offset = v;
                REG_SENS:  sens = v[7:0];
                default:   ;
            endcase
        endfunction

        function void take_tick(logic signed [15:0] tgt, logic signed [15:0] meas);
            longint t, m, err, base, tp, ti, td, u, q, off, drv;
            longint kf, kp, ki, kd, sm, sn;
            tick_t  item;
            t  = tgt;
            m  = meas;
            kf = ff_gain;
            kp = p_gain;
            ki = i_gain;
            kd = d_gain;
            sm = smax;
            sn = sens;
            item.tgt  = tgt;
            item.meas = meas;
            err = wrap16(t - m);
            if (err > LAUNCH_ON)
                launching = 1'b1;
            if (launching)
            begin
                // Launch holds the drive at full scale and freezes the integrator.
                if (err < LAUNCH_OFF)
                    launching = 1'b0;
                item.drive = {1'b0, smax};
            end
            else
            begin
                base = wrap16(t * kf);
                tp   = wrap16(err * kp);
                ti   = wrap16((longint'(err_sum) * ki) / 100);
                td   = wrap16(wrap16(err - longint'(last_err)) * kd);
                u    = wrap16(base + tp + ti + td);
                last_err = err[15:0];
                err_sum  = wrap16(longint'(err_sum) + err);
                q    = (sm != 0) ? (100 * u) / sm : 0;
                off  = (m != 0) ? longint'(run_offset) : longint'(rest_offset);
                drv  = wrap16(off + q * sn);
                item.drive = drv[15:0];
            end
            drive_due.push_back(item);
        endfunction

        function void check_drive(logic [15:0] got);
            tick_t item;
            if (drive_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected drive word %0d", $signed(got));
            end
            else
            begin
                item = drive_due.pop_front();
                if (item.drive !== got)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("drive mismatch: target %0d measured %0d expected %0d got %0d",
                                 item.tgt, item.meas, item.drive, $signed(got));
                end
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_wdata = '0;

    drive_tracker tracker = new();
    logic [15:0]  reg_plan [8];
    bit           no_idle = 1'b0;
    int           idle_cycles = 0;

    motor_speed_pid_with_launch dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic send_tick(input logic [15:0] tgt, input logic [15:0] meas);
        while (!no_idle && $urandom_range(0, 99) < 15)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {meas, tgt};
        do
            @(posedge clk);
        while (!s_axis_tready);
        tracker.take_tick(tgt, meas);
    endtask

    task automatic send_random_tick();
        logic [15:0] tgt, meas;
        int          r;
        r = $urandom_range(0, 99);
        if (r < 45)
        begin
            // Errors around the launch thresholds.
            meas = 16'($urandom);
            tgt  = meas + 16'($urandom_range(0, 45)) - 16'd20;
        end
        else if (r < 60)
        begin
            meas = '0;
            tgt  = 16'($urandom_range(0, 40)) - 16'd10;
        end
        else
        begin
            meas = 16'($urandom);
            tgt  = 16'($urandom);
        end
        send_tick(tgt, meas);
    endtask

    // Lets the block drain so that settings may change.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (tracker.drive_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    task automatic apply_plan();
        msp_reg_t ri;
        ri = ri.first();
        repeat (ri.num())
        begin
            cfg_we    <= 1'b1;
            cfg_index <= ri;
            cfg_wdata <= reg_plan[ri];
            tracker.set_reg(ri, reg_plan[ri]);
            @(posedge clk);
            ri = ri.next();
        end
        cfg_we <= 1'b0;
    endtask

    function automatic logic [15:0] pick_reg(msp_reg_t idx);
        int w;
        int r;
        w = (idx == REG_SMAX) ? SMAX_W : (idx == REG_SENS) ? SENS_W : GAIN_W;
        r = $urandom_range(0, 3);
        if (idx == REG_DRUN || idx == REG_DREST)
            return (r == 0) ? 16'h8000 : (r == 1) ? 16'h7FFF : 16'($urandom);
        case (r)
            0:       return '0;
            1:       return 16'((1 << w) - 1);
            2:       return 16'($urandom);
            default: return 16'($urandom_range((1 << w) - 1, 0));
        endcase
    endfunction

    initial
    begin
        int       got;
        int       hold;
        got  = 0;
        hold = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
            begin
                tracker.check_drive(m_axis_tdata);
                got++;
                if (got == 150)
                    hold = RX_HOLD;
            end
            if (hold > 0)
            begin
                hold--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= no_idle || ($urandom_range(0, 99) >= 15);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("** motor_speed_pid_with_launch: FAILED **");
                $finish;
            end
        end
    end

    initial
    begin
        msp_reg_t ri;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: launch entry, hold and exit, plus wrapping errors.
        send_tick(16'sd20, 16'sd0);
        send_tick(16'sd10, 16'sd0);
        send_tick(16'sd3, 16'sd0);
        send_tick(16'sd0, 16'sd0);
        send_tick(16'sd16, 16'sd0);
        send_tick(16'sd4, 16'sd0);
        send_tick(16'sd15, 16'sd0);
        send_tick(16'h7FFF, 16'h8000);
        send_tick(16'h8000, 16'h7FFF);
        send_tick(16'h8000, 16'h8000);
        send_tick(16'h7FFF, 16'h7FFF);
        settle();

        // Every gain at full scale with the smallest divisor.
        reg_plan[REG_FF]    = 16'd1023;
        reg_plan[REG_KP]    = 16'd1023;
        reg_plan[REG_KI]    = 16'd1023;
        reg_plan[REG_KD]    = 16'd1023;
        reg_plan[REG_SMAX]  = 16'd1;
        reg_plan[REG_DRUN]  = 16'h7FFF;
        reg_plan[REG_DREST] = 16'h8000;
        reg_plan[REG_SENS]  = 16'd255;
        apply_plan();
        send_tick(16'h8000, 16'h0000);
        send_tick(16'h7FFF, 16'h7FF6);
        send_tick(16'hFFFF, 16'hFFFF);
        send_tick(16'h0000, 16'hFFFF);
        send_tick(16'h0005, 16'h0000);
        send_tick(16'h8000, 16'hFFFF);
        send_tick(16'h7FFF, 16'h7FFF);
        send_tick(16'hFFF0, 16'h0001);
        settle();

        // A zero divisor: launch drives zero and the scaled term vanishes.
        reg_plan[REG_FF]    = 16'd3;
        reg_plan[REG_KP]    = 16'd7;
        reg_plan[REG_KI]    = 16'd50;
        reg_plan[REG_KD]    = 16'd2;
        reg_plan[REG_SMAX]  = 16'd0;
        reg_plan[REG_DRUN]  = 16'd5;
        reg_plan[REG_DREST] = 16'hFFF9;
        reg_plan[REG_SENS]  = 16'd9;
        apply_plan();
        send_tick(16'sd20, 16'sd0);
        send_tick(16'sd0, 16'sd0);
        send_tick(-16'sd3, 16'sd1);
        send_tick(16'sd100, 16'sd100);
        settle();

        for (int set_no = 0; set_no < RANDOM_SETS; set_no++)
        begin
            ri = ri.first();
            repeat (ri.num())
            begin
                reg_plan[ri] = pick_reg(ri);
                ri = ri.next();
            end
            // Keep the divisor nonzero in most sets so the output scaling is exercised.
            if (set_no % 3 != 0 && reg_plan[REG_SMAX][14:0] == 0)
                reg_plan[REG_SMAX] = 16'($urandom_range(32767, 1));
            apply_plan();
            no_idle = (set_no == 3);
            repeat (RANDOM_TICKS) send_random_tick();
            settle();
        end

        if (tracker.mismatches == 0 && tracker.drive_due.size() == 0)
            $display("** motor_speed_pid_with_launch: PASSED **");
        else
            $display("** motor_speed_pid_with_launch: FAILED **");
        $finish;
    end

endmodule
